// ----- src/gb3_pkg.sv -----
// Shared types, constants and the blur kernel for the 3x3 Gaussian blur block.
// No dependencies; imported by the top level and its checker.
package gb3_pkg;

	localparam int GB3_MAX_WIDTH     = 2048;
	localparam int GB3_PIX_W         = 8;
	localparam int GB3_ROW_W         = 16;
	localparam int GB3_COL_W         = 11;
	localparam int GB3_FW_W          = 12;
	localparam int GB3_QUEUE_DEPTH   = 8;
	localparam int GB3_RESULTS_MAX   = 2;
	localparam int CFG_INDEX_W       = 2;
	localparam int CFG_DATA_W        = 16;

	localparam logic [CFG_INDEX_W-1:0] REG_FRAME_WIDTH  = CFG_INDEX_W'(0);
	localparam logic [CFG_INDEX_W-1:0] REG_FRAME_HEIGHT = CFG_INDEX_W'(1);

	localparam logic [GB3_FW_W-1:0]  RESET_FRAME_WIDTH  = GB3_FW_W'(640);
	localparam logic [GB3_ROW_W-1:0] RESET_FRAME_HEIGHT = GB3_ROW_W'(480);

	typedef enum logic {
		CMD_PIXEL = 1'b0,
		CMD_DRAIN = 1'b1
	} gb3_cmd_t;

	typedef struct packed {
		gb3_cmd_t             command;
		logic [GB3_PIX_W-1:0] pixel_in;
	} pix_item_t;

	typedef struct packed {
		logic [GB3_PIX_W-1:0] blurred;
		logic [GB3_ROW_W-1:0] out_row;
		logic [GB3_COL_W-1:0] out_col;
		logic                 last_of_run;
		logic                 end_of_frame;
	} res_item_t;

	function automatic logic [GB3_PIX_W-1:0] blur9(
		input logic [GB3_PIX_W-1:0] t0, input logic [GB3_PIX_W-1:0] t1,
		input logic [GB3_PIX_W-1:0] t2, input logic [GB3_PIX_W-1:0] m0,
		input logic [GB3_PIX_W-1:0] m1, input logic [GB3_PIX_W-1:0] m2,
		input logic [GB3_PIX_W-1:0] b0, input logic [GB3_PIX_W-1:0] b1,
		input logic [GB3_PIX_W-1:0] b2
	);
		logic [11:0] s;
		s = 12'(t0) + {3'b0, t1, 1'b0} + 12'(t2)
			+ {3'b0, m0, 1'b0} + {2'b0, m1, 2'b0} + {3'b0, m2, 1'b0}
			+ 12'(b0) + {3'b0, b1, 1'b0} + 12'(b2);
		return s[11:4];
	endfunction

endpackage

// ----- src/gaussian_blur_3x3_clamped.sv -----
// 3x3 Gaussian blur with clamped edges over a raster pixel stream.
// Uses gb3_pkg for item types, register indexes and the blur kernel.
//
//  channel   direction  handshake                 payload
//  pixel     in         pixel_valid/pixel_stall   pix_item_t  (command, pixel_in)
//  result    out        result_valid/result_stall res_item_t  (blurred, row, col, flags)
//  cfg       in         cfg_valid/cfg_ready       cfg_index, cfg_data
//
// One item per cycle while pixel_stall is low; a result passes the s1 register and the result queue.
// The line store (both previous rows in one word, one read and one write port) is read once
// per item and written for pixel items in the next cycle, with forwarding when consecutive
// items touch the same column. A row end after row 0 gives two results (one if the frame is
// one column wide); the 8-entry result queue stalls the pixel channel while more than four results wait.
// Reset clears counters, pipeline and queue; the line store is not cleared.
module gaussian_blur_3x3_clamped
	import gb3_pkg::*;
#(
	parameter int MAX_WIDTH = GB3_MAX_WIDTH
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   pixel_valid,
	output logic                   pixel_stall,
	input  pix_item_t              pixel_item,
	output logic                   result_valid,
	input  logic                   result_stall,
	output res_item_t              result_item,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	localparam int CW  = $clog2(MAX_WIDTH);
	localparam int QW  = $clog2(GB3_QUEUE_DEPTH);
	localparam int QCW = $clog2(GB3_QUEUE_DEPTH + 1);
	localparam int PW  = GB3_PIX_W;
	localparam int RW  = GB3_ROW_W;

	logic [GB3_FW_W-1:0] frame_width_q;
	logic [RW-1:0]       frame_height_q;
	logic [CW-1:0]       w_last;
	logic [RW-1:0]       eff_h;
	logic [RW-1:0]       h_last;
	logic                h_one;

	logic [CW-1:0] col_q;
	logic [RW-1:0] row_q;
	logic [CW-1:0] drain_q;
	logic [CW-1:0] kr;

	logic          cfg_wr;
	logic          cfg_hit;
	logic          accept;
	logic          pix_go;
	logic          drn_go;
	logic [CW-1:0] rd_addr;

	logic [2*PW-1:0] line_mem [MAX_WIDTH];
	logic [2*PW-1:0] rdata_q;

	logic            pix_s1;
	logic            drn_s1;
	logic [PW-1:0]   px_s1;
	logic [CW-1:0]   col_s1;
	logic [RW-1:0]   row_s1;
	logic            eol_s1;
	logic            col1_s1;
	logic            first_s1;
	logic            top_s1;
	logic            rowz_s1;
	logic            bot_s1;
	logic            klast_s1;
	logic            fwd_s1;
	logic [2*PW-1:0] fwd_line_s1;

	logic [2*PW-1:0] line_s1;
	logic [PW-1:0]   up_s1;
	logic [PW-1:0]   prv_s1;

	logic [PW-1:0] win_q [3][3];
	logic [PW-1:0] nw    [3][3];
	logic [PW-1:0] cap_mid_q;
	logic [PW-1:0] cap_up_q;
	logic [PW-1:0] dmid_c_q;
	logic [PW-1:0] dmid_r_q;
	logic [PW-1:0] dup_c_q;
	logic [PW-1:0] dup_r_q;
	logic [PW-1:0] dm_l, dm_c, dm_r, du_l, du_c, du_r;

	logic [PW-1:0] t1_l, t1_c, t1_r, t2_l;
	logic [PW-1:0] m1_l, b1_l, m2_l, b2_l;

	res_item_t       item_a;
	res_item_t       item_b;
	logic            push_a;
	logic            push_b;
	logic            pop;
	res_item_t       queue_q [GB3_QUEUE_DEPTH];
	logic [QW-1:0]   wp_q;
	logic [QW-1:0]   rp_q;
	logic [QCW-1:0]  count_q;

	// effective frame geometry
	always_comb begin
		if (frame_width_q == '0) begin
			w_last = '0;
		end else if (32'(frame_width_q) > 32'(MAX_WIDTH)) begin
			w_last = CW'(MAX_WIDTH - 1);
		end else begin
			w_last = CW'(frame_width_q - GB3_FW_W'(1));
		end
		eff_h  = (frame_height_q == '0) ? RW'(1) : frame_height_q;
		h_last = eff_h - RW'(1);
		h_one  = (eff_h == RW'(1));
	end

	assign cfg_ready   = 1'b1;
	assign cfg_wr      = cfg_valid && cfg_ready;
	assign cfg_hit     = cfg_wr && (cfg_index == REG_FRAME_WIDTH || cfg_index == REG_FRAME_HEIGHT);
	assign pixel_stall = (count_q > QCW'(GB3_QUEUE_DEPTH - 2 * GB3_RESULTS_MAX));
	assign accept      = pixel_valid && !pixel_stall;
	assign pix_go      = accept && pixel_item.command == CMD_PIXEL && row_q < eff_h;
	assign drn_go      = accept && pixel_item.command == CMD_DRAIN && row_q == eff_h;
	assign kr          = (drain_q == w_last) ? drain_q : drain_q + CW'(1);
	assign rd_addr     = pix_go ? col_q : kr;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= RESET_FRAME_WIDTH;
			frame_height_q <= RESET_FRAME_HEIGHT;
		end else if (cfg_wr) begin
			unique case (cfg_index)
				REG_FRAME_WIDTH:  frame_width_q  <= cfg_data[GB3_FW_W-1:0];
				REG_FRAME_HEIGHT: frame_height_q <= cfg_data[RW-1:0];
				default: ;
			endcase
		end
	end

	// raster and drain position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q   <= '0;
			row_q   <= '0;
			drain_q <= '0;
		end else begin
			priority if (cfg_hit) begin
				col_q   <= '0;
				row_q   <= '0;
				drain_q <= '0;
			end else if (pix_go) begin
				if (col_q == w_last) begin
					col_q <= '0;
					row_q <= row_q + RW'(1);
				end else begin
					col_q <= col_q + CW'(1);
				end
			end else if (drn_go) begin
				if (drain_q == w_last) begin
					col_q   <= '0;
					row_q   <= '0;
					drain_q <= '0;
				end else begin
					drain_q <= drain_q + CW'(1);
				end
			end else begin
			end
		end
	end

	// line store: read at transfer, write back of pixel items in the next cycle
	always_ff @(posedge clk) begin
		if (pix_go || drn_go) begin
			rdata_q <= line_mem[rd_addr];
		end
		if (pix_s1) begin
			line_mem[col_s1] <= {px_s1, prv_s1};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pix_s1 <= 1'b0;
			drn_s1 <= 1'b0;
			fwd_s1 <= 1'b0;
		end else begin
			pix_s1 <= pix_go;
			drn_s1 <= drn_go;
			fwd_s1 <= (pix_go || drn_go) && pix_s1 && rd_addr == col_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (pix_go || drn_go) begin
			px_s1       <= pixel_item.pixel_in;
			col_s1      <= pix_go ? col_q : drain_q;
			row_s1      <= row_q;
			eol_s1      <= col_q == w_last;
			col1_s1     <= col_q == CW'(1);
			first_s1    <= col_q == '0;
			top_s1      <= row_q == RW'(1);
			rowz_s1     <= row_q == '0;
			bot_s1      <= row_q == h_last;
			klast_s1    <= drain_q == w_last;
			fwd_line_s1 <= {px_s1, prv_s1};
		end
	end

	assign line_s1 = fwd_s1 ? fwd_line_s1 : rdata_q;
	assign prv_s1  = line_s1[2*PW-1:PW];
	assign up_s1   = h_one ? prv_s1 : line_s1[PW-1:0];

	// shifted window: rows r-2, r-1, r by columns c-2, c-1, c
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			nw[i][0] = win_q[i][1];
			nw[i][1] = win_q[i][2];
		end
		nw[0][2] = line_s1[PW-1:0];
		nw[1][2] = prv_s1;
		nw[2][2] = px_s1;
	end

	always_ff @(posedge clk) begin
		if (pix_s1) begin
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					win_q[i][j] <= nw[i][j];
				end
			end
			if (first_s1 && bot_s1) begin
				cap_mid_q <= px_s1;
				cap_up_q  <= h_one ? px_s1 : prv_s1;
			end
		end
		if (drn_s1) begin
			dmid_c_q <= dm_c;
			dmid_r_q <= dm_r;
			dup_c_q  <= du_c;
			dup_r_q  <= du_r;
		end
	end

	// drain window: left and center come from the previous step, or column 0
	always_comb begin
		dm_r = prv_s1;
		du_r = up_s1;
		if (col_s1 == '0) begin
			dm_l = cap_mid_q;
			dm_c = cap_mid_q;
			du_l = cap_up_q;
			du_c = cap_up_q;
		end else begin
			dm_l = dmid_c_q;
			dm_c = dmid_r_q;
			du_l = dup_c_q;
			du_c = dup_r_q;
		end
	end

	always_comb begin
		t1_l = top_s1 ? (col1_s1 ? nw[1][1] : nw[1][0]) : (col1_s1 ? nw[0][1] : nw[0][0]);
		t1_c = top_s1 ? nw[1][1] : nw[0][1];
		t1_r = top_s1 ? nw[1][2] : nw[0][2];
		m1_l = col1_s1 ? nw[1][1] : nw[1][0];
		b1_l = col1_s1 ? nw[2][1] : nw[2][0];
		t2_l = (w_last != '0) ? t1_c : t1_r;
		m2_l = (w_last != '0) ? nw[1][1] : nw[1][2];
		b2_l = (w_last != '0) ? nw[2][1] : nw[2][2];
	end

	always_comb begin
		item_a = '0;
		item_b = '0;
		push_a = 1'b0;
		push_b = 1'b0;
		if (pix_s1) begin
			push_a              = !rowz_s1 && !first_s1;
			item_a.blurred      = blur9(t1_l, t1_c, t1_r, m1_l, nw[1][1], nw[1][2],
				b1_l, nw[2][1], nw[2][2]);
			item_a.out_row      = row_s1 - RW'(1);
			item_a.out_col      = GB3_COL_W'(col_s1 - CW'(1));
			item_a.last_of_run  = !eol_s1;
			item_a.end_of_frame = 1'b0;
			push_b              = !rowz_s1 && eol_s1;
			item_b.blurred      = blur9(t2_l, t1_r, t1_r, m2_l, nw[1][2], nw[1][2],
				b2_l, nw[2][2], nw[2][2]);
			item_b.out_row      = row_s1 - RW'(1);
			item_b.out_col      = GB3_COL_W'(w_last);
			item_b.last_of_run  = 1'b1;
			item_b.end_of_frame = 1'b0;
		end else if (drn_s1) begin
			push_a              = 1'b1;
			item_a.blurred      = blur9(du_l, du_c, du_r, dm_l, dm_c, dm_r, dm_l, dm_c, dm_r);
			item_a.out_row      = h_last;
			item_a.out_col      = GB3_COL_W'(col_s1);
			item_a.last_of_run  = 1'b1;
			item_a.end_of_frame = klast_s1;
		end
	end

	// result queue
	assign result_valid = count_q != '0;
	assign result_item  = queue_q[rp_q];
	assign pop          = result_valid && !result_stall;

	always_ff @(posedge clk) begin
		if (push_a) begin
			queue_q[wp_q] <= item_a;
		end
		if (push_b) begin
			queue_q[push_a ? wp_q + QW'(1) : wp_q] <= item_b;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q    <= '0;
			rp_q    <= '0;
			count_q <= '0;
		end else begin
			wp_q    <= wp_q + QW'(push_a) + QW'(push_b);
			rp_q    <= rp_q + QW'(pop);
			count_q <= count_q + QCW'(push_a) + QCW'(push_b) - QCW'(pop);
		end
	end

endmodule

// ----- src/gb3_checker.sv -----
// Port-level checks for gaussian_blur_3x3_clamped, bound to the top level.
// Depends on gb3_pkg for the item types.
module gb3_checker
	import gb3_pkg::*;
(
	input logic      clk,
	input logic      arst_n,
	input logic      pixel_valid,
	input logic      pixel_stall,
	input logic      result_valid,
	input logic      result_stall,
	input res_item_t result_item
);

	// hold a stalled result
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result_item))
		else $error("stalled result changed or dropped");

	a_rise_after_transfer: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(pixel_valid && !pixel_stall, 2))
		else $error("result appeared without a pixel transfer two cycles earlier");

	a_stall_needs_backlog: assert property (@(posedge clk) disable iff (!arst_n)
		pixel_stall |-> result_valid)
		else $error("pixel channel stalled with no result waiting");

	a_eof_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_item.end_of_frame |-> result_item.last_of_run)
		else $error("end of frame on a result that is not the last of its run");

endmodule

bind gaussian_blur_3x3_clamped gb3_checker u_gb3_checker (.*);
